### rtl/core/jfbp_pkg.sv
// Shared codes, types and constants of the JPEG frame buffer pool.
package jfbp_pkg;

    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_PUSH    = 3'd1;
    localparam logic [2:0] REQ_PULL    = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_BADJPEG  = 3'd4;

    localparam logic [7:0] MARK_FF  = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_EOI = 8'hD9;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COPY,
        S_SCAN,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        restart_capture;
        logic [7:0]  read_byte;
        logic [11:0] frame_len;
        logic [1:0]  slot_out;
        logic [2:0]  status;
    } result_t;

endpackage

### rtl/core/jfbp_ram.sv
// Generic simple dual-port RAM with registered read.
module jfbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/jpeg_frame_buffer_pool.sv
// Top level: capture buffer, frame slots and queue of filled slots.
//
//  channel | dir | handshake           | payload
//  s       | in  | s_tvalid / s_tready | s_tuser req_type; s_tdata addr, byte, slot
//  m       | out | m_tvalid / m_tready | m_tdata status, slot, length, byte, restart
//
// Write, release, failed push, empty/released pull, bad or unknown request: direct to output if free.
// Push copy: one byte per cycle through the capture RAM read port.
// Pull scan: one byte per cycle through the slot RAM read port.
// Read: S_READ captures the registered slot RAM data. Output register takes a result while s waits.
// After reset a clearing pass zeroes every capture RAM address; s_tready is low during it.
module jpeg_frame_buffer_pool #(
    parameter int SLOTS       = 4,
    parameter int FRAME_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // byte_addr[11:0], byte_value[19:12], slot_sel[21:20]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[2:0], slot_out[4:3], frame_len[16:5],
                                   // read_byte[24:17], restart_capture[25]
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] SCAN_LAST = AW'(FRAME_BYTES - 2);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C   = CW'(SLOTS);

    jfbp_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              cnt_done_reg, cnt_done_next;
    logic              dv_reg, dv_next;
    logic [AW-1:0]     didx_reg, didx_next;
    logic [7:0]        prev_reg, prev_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic [SLOTS-1:0]  filled_reg, filled_next;
    logic [SW-1:0]     head_reg, head_next;
    logic [SW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SW-1:0]     fifo_mem [SLOTS];
    logic              fifo_we;
    jfbp_pkg::result_t res_reg, res_next;
    jfbp_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    jfbp_pkg::result_t res_n;
    logic              imm;
    logic              out_free;

    logic [2:0]        req;
    logic [31:0]       addr_w, sel_w, found_w, idx_w, len_w;
    logic [AW-1:0]     addr_m;
    logic [SW-1:0]     sel_m;
    logic              addr_ok, sel_ok;
    logic [SW-1:0]     found;
    logic              found_any;
    logic [SW-1:0]     idx;

    logic              cap_we, cap_re;
    logic [AW-1:0]     cap_waddr, cap_raddr;
    logic [7:0]        cap_wdata, cap_rdata;
    logic              slot_we, slot_re;
    logic [SW+AW-1:0]  slot_waddr, slot_raddr;
    logic [7:0]        slot_wdata, slot_rdata;

    jfbp_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_cap_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .re    (cap_re),
        .raddr (cap_raddr),
        .rdata (cap_rdata)
    );

    jfbp_ram #(.WIDTH(8), .DEPTH(1 << (SW + AW))) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign req     = s_tuser;
    assign addr_w  = 32'(s_tdata[11:0]);
    assign sel_w   = 32'(s_tdata[21:20]);
    assign addr_m  = addr_w[AW-1:0];
    assign sel_m   = sel_w[SW-1:0];
    assign addr_ok = addr_w < 32'(FRAME_BYTES);
    assign sel_ok  = sel_w < 32'(SLOTS);
    assign idx     = fifo_mem[head_reg];
    assign found_w = 32'(found);
    assign idx_w   = 32'(idx);
    assign len_w   = 32'(didx_reg) + 32'd1;

    always_comb
    begin
        found     = '0;
        found_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                found     = SW'(i);
                found_any = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cnt_done_next  = cnt_done_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        prev_next      = prev_reg;
        slot_next      = slot_reg;
        used_next      = used_reg;
        filled_next    = filled_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fifo_we        = 1'b0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_n          = '0;
        imm            = 1'b0;
        s_tready       = 1'b0;
        cap_we         = 1'b0;
        cap_waddr      = addr_m;
        cap_wdata      = s_tdata[19:12];
        cap_re         = 1'b0;
        cap_raddr      = cnt_reg;
        slot_we        = 1'b0;
        slot_waddr     = {slot_reg, didx_reg};
        slot_wdata     = cap_rdata;
        slot_re        = 1'b0;
        slot_raddr     = {slot_reg, cnt_reg};

        case (state_reg)
            jfbp_pkg::S_CLEAR:
            begin
                cap_we    = 1'b1;
                cap_waddr = cnt_reg;
                cap_wdata = '0;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = jfbp_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            jfbp_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cnt_next      = '0;
                    cnt_done_next = 1'b0;
                    case (req)
                        jfbp_pkg::REQ_WRITE:
                        begin
                            cap_we = addr_ok;
                            imm    = 1'b1;
                        end
                        jfbp_pkg::REQ_PUSH:
                        begin
                            res_n.restart_capture = 1'b1;
                            if (count_reg < SLOTS_C && found_any)
                            begin
                                used_next[found]   = 1'b1;
                                filled_next[found] = 1'b1;
                                fifo_we            = 1'b1;
                                tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                                res_n.slot_out     = found_w[1:0];
                                slot_next          = found;
                                state_next         = jfbp_pkg::S_COPY;
                            end
                            else
                            begin
                                res_n.status = jfbp_pkg::ST_FULL;
                                imm          = 1'b1;
                            end
                        end
                        jfbp_pkg::REQ_PULL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_n.status = jfbp_pkg::ST_EMPTY;
                                imm          = 1'b1;
                            end
                            else
                            begin
                                head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                res_n.slot_out = idx_w[1:0];
                                if (!used_reg[idx])
                                begin
                                    res_n.status = jfbp_pkg::ST_RELEASED;
                                    imm          = 1'b1;
                                end
                                else
                                begin
                                    slot_next  = idx;
                                    state_next = jfbp_pkg::S_SCAN;
                                end
                            end
                        end
                        jfbp_pkg::REQ_RELEASE:
                        begin
                            if (sel_ok)
                            begin
                                used_next[sel_m] = 1'b0;
                            end
                            imm = 1'b1;
                        end
                        jfbp_pkg::REQ_READ:
                        begin
                            if (sel_ok && addr_ok && filled_reg[sel_m])
                            begin
                                slot_re    = 1'b1;
                                slot_raddr = {sel_m, addr_m};
                                state_next = jfbp_pkg::S_READ;
                            end
                            else
                            begin
                                imm = 1'b1;
                            end
                        end
                        default:
                        begin
                            imm = 1'b1;
                        end
                    endcase
                    res_next = res_n;
                    if (imm)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = res_n;
                        end
                        else
                        begin
                            state_next = jfbp_pkg::S_DONE;
                        end
                    end
                end
            end
            jfbp_pkg::S_COPY:
            begin
                cap_re    = !cnt_done_reg;
                dv_next   = !cnt_done_reg;
                didx_next = cnt_reg;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                slot_we = dv_reg;
                if (dv_reg && didx_reg == LAST_ADDR)
                begin
                    state_next = jfbp_pkg::S_DONE;
                end
            end
            jfbp_pkg::S_SCAN:
            begin
                slot_re   = !cnt_done_reg;
                dv_next   = !cnt_done_reg;
                didx_next = cnt_reg;
                if (cnt_reg == SCAN_LAST)
                begin
                    cnt_done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    prev_next = slot_rdata;
                    if (didx_reg == '0)
                    begin
                        prev_next = slot_rdata;
                    end
                    else if (didx_reg == AW'(1))
                    begin
                        if (!(prev_reg == jfbp_pkg::MARK_FF && slot_rdata == jfbp_pkg::MARK_SOI))
                        begin
                            used_next[slot_reg] = 1'b0;
                            res_next.status     = jfbp_pkg::ST_BADJPEG;
                            state_next          = jfbp_pkg::S_DONE;
                        end
                    end
                    else if (prev_reg == jfbp_pkg::MARK_FF && slot_rdata == jfbp_pkg::MARK_SOI)
                    begin
                        used_next[slot_reg] = 1'b0;
                        res_next.status     = jfbp_pkg::ST_BADJPEG;
                        state_next          = jfbp_pkg::S_DONE;
                    end
                    else if (prev_reg == jfbp_pkg::MARK_FF && slot_rdata == jfbp_pkg::MARK_EOI)
                    begin
                        res_next.frame_len = len_w[11:0];
                        state_next         = jfbp_pkg::S_DONE;
                    end
                    else if (didx_reg == SCAN_LAST)
                    begin
                        used_next[slot_reg] = 1'b0;
                        res_next.status     = jfbp_pkg::ST_BADJPEG;
                        state_next          = jfbp_pkg::S_DONE;
                    end
                end
            end
            jfbp_pkg::S_READ:
            begin
                res_next.read_byte = slot_rdata;
                state_next         = jfbp_pkg::S_DONE;
            end
            jfbp_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = jfbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = jfbp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jfbp_pkg::S_CLEAR;
            cnt_reg       <= '0;
            cnt_done_reg  <= 1'b0;
            dv_reg        <= 1'b0;
            used_reg      <= '0;
            filled_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cnt_done_reg  <= cnt_done_next;
            dv_reg        <= dv_next;
            used_reg      <= used_next;
            filled_reg    <= filled_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg <= didx_next;
        prev_reg <= prev_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= found;
        end
    end

endmodule

### rtl/core/jfbp_checker.sv
// Port-level checks on the result stream of the frame buffer pool, with bind.
module jfbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [2:0] status;

    assign status = m_tdata[2:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_restart_push: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25] |->
            status == jfbp_pkg::ST_OK || status == jfbp_pkg::ST_FULL)
        else $error("restart pulse on a non-push status");

    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16:5] != 12'd0 |->
            status == jfbp_pkg::ST_OK && !m_tdata[25] && m_tdata[24:17] == 8'd0)
        else $error("frame length on a failed or foreign transaction");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == jfbp_pkg::ST_EMPTY |->
            m_tdata[4:3] == 2'd0 && m_tdata[16:5] == 12'd0 && m_tdata[24:17] == 8'd0)
        else $error("empty pull carries payload");

endmodule

bind jpeg_frame_buffer_pool jfbp_checker u_jfbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/tb_top.sv
// Self-checking testbench for the JPEG frame buffer pool: queued requests against a behavioral pool.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jfbp_pkg::*;

    localparam int SLOTS       = 4;
    localparam int FRAME_BYTES = 4096;
    localparam int ITEM_TARGET = 550;
    localparam int MAX_CYCLES  = 3_000_000;
    localparam int TAIL_CYCLES = 64;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] addr;
        logic [7:0]  value;
        logic [1:0]  slot;
    } request_t;

    typedef enum int {FLAW_NONE, FLAW_BAD_SOI, FLAW_EXTRA_SOI, FLAW_NO_EOI} flaw_t;
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    class pool_scoreboard;
        logic [7:0]  capture_bytes [FRAME_BYTES];
        logic [7:0]  slot_bytes [SLOTS][FRAME_BYTES];
        bit          slot_busy [SLOTS];
        int unsigned filled_queue [SLOTS];
        int unsigned q_head;
        int unsigned q_tail;
        int unsigned q_count;
        result_t     awaited_responses [$];
        int unsigned error_count;

        function new();
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                capture_bytes[i] = 8'h00;
                for (int s = 0; s < SLOTS; s++)
                    slot_bytes[s][i] = 8'h00;
            end
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_busy[s]    = 1'b0;
                filled_queue[s] = 0;
            end
            q_head      = 0;
            q_tail      = 0;
            q_count     = 0;
            error_count = 0;
        endfunction

        // Length through the end marker, 0 for a broken image.
        function logic [11:0] frame_length(int unsigned s);
            if (slot_bytes[s][0] != MARK_FF || slot_bytes[s][1] != MARK_SOI)
                return 12'd0;
            for (int unsigned i = 1; i < FRAME_BYTES - 2; i++)
            begin
                if (slot_bytes[s][i] == MARK_FF && slot_bytes[s][i + 1] == MARK_SOI)
                    return 12'd0;
                if (slot_bytes[s][i] == MARK_FF && slot_bytes[s][i + 1] == MARK_EOI)
                    return 12'(i + 2);
            end
            return 12'd0;
        endfunction

        function void note_request(request_t r);
            result_t     want;
            int unsigned free_slot;
            int unsigned idx;
            want = '0;
            case (r.kind)
                REQ_WRITE:
                    capture_bytes[r.addr] = r.value;
                REQ_PUSH:
                begin
                    want.restart_capture = 1'b1;
                    free_slot = SLOTS;
                    if (q_count < SLOTS)
                        for (int unsigned s = 0; s < SLOTS; s++)
                            if (!slot_busy[s] && free_slot == SLOTS)
                                free_slot = s;
                    if (free_slot < SLOTS)
                    begin
                        for (int i = 0; i < FRAME_BYTES; i++)
                            slot_bytes[free_slot][i] = capture_bytes[i];
                        slot_busy[free_slot]  = 1'b1;
                        filled_queue[q_tail] = free_slot;
                        q_tail               = (q_tail + 1) % SLOTS;
                        q_count++;
                        want.slot_out = 2'(free_slot);
                    end
                    else
                        want.status = ST_FULL;
                end
                REQ_PULL:
                begin
                    if (q_count == 0)
                        want.status = ST_EMPTY;
                    else
                    begin
                        idx    = filled_queue[q_head];
                        q_head = (q_head + 1) % SLOTS;
                        q_count--;
                        want.slot_out = 2'(idx);
                        if (!slot_busy[idx])
                            want.status = ST_RELEASED;
                        else
                        begin
                            want.frame_len = frame_length(idx);
                            if (want.frame_len == 12'd0)
                            begin
                                slot_busy[idx] = 1'b0;
                                want.status    = ST_BADJPEG;
                            end
                        end
                    end
                end
                REQ_RELEASE:
                    slot_busy[r.slot] = 1'b0;
                REQ_READ:
                    want.read_byte = slot_bytes[r.slot][r.addr];
                default:
                    ;
            endcase
            awaited_responses.push_back(want);
        endfunction

        function void compare_field(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_response(logic [31:0] data);
            result_t got;
            result_t want;
            got = data;
            if (awaited_responses.size() == 0)
            begin
                $error("unexpected response transaction: %h", data);
                error_count++;
                return;
            end
            want = awaited_responses.pop_front();
            compare_field("status", 12'(want.status), 12'(got.status));
            compare_field("slot_out", 12'(want.slot_out), 12'(got.slot_out));
            compare_field("frame_len", want.frame_len, got.frame_len);
            compare_field("read_byte", 12'(want.read_byte), 12'(got.read_byte));
            compare_field("restart_capture", 12'(want.restart_capture),
                          12'(got.restart_capture));
        endfunction

        function int unsigned pending_count();
            return awaited_responses.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    pool_scoreboard board;
    int unsigned    sent_items    = 0;
    int unsigned    burst_left    = 0;
    int unsigned    hold_off_left = 0;
    int unsigned    cycle_count   = 0;

    jpeg_frame_buffer_pool #(
        .SLOTS       (SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic request_t make_req(logic [2:0] kind, logic [11:0] addr,
                                          logic [7:0] value, logic [1:0] slot);
        request_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.value = value;
        r.slot  = slot;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_request(make_req(s_tuser, s_tdata[11:0], s_tdata[19:12],
                                            s_tdata[21:20]));
            if (m_tvalid && m_tready)
                board.check_response(m_tdata);
        end
    end

    // Receiver: phases of steady, random or patterned ready, plus an optional long hold-off.
    initial
    begin
        int unsigned phase_left;
        int unsigned tick;
        rx_mode_t    mode;
        logic [7:0]  ready_mask;
        phase_left = 0;
        tick       = 0;
        mode       = RX_ALWAYS;
        ready_mask = 8'hFF;
        @(posedge clk);
        forever
        begin
            if (phase_left == 0)
            begin
                mode       = rx_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(16, 256);
                ready_mask = 8'($urandom_range(1, 255));
            end
            phase_left--;
            tick++;
            if (hold_off_left != 0)
            begin
                hold_off_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ready_mask[tick % 8];
                endcase
            @(posedge clk);
        end
    end

    function automatic request_t random_request();
        int unsigned pick;
        logic [11:0] addr;
        pick = $urandom_range(0, 99);
        addr = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63)) :
                                             12'($urandom_range(0, FRAME_BYTES - 1));
        if (pick < 35)
            return make_req(REQ_WRITE, addr, 8'($urandom), 2'($urandom));
        if (pick < 55)
            return make_req(REQ_READ, addr, 8'($urandom), 2'($urandom));
        if (pick < 70)
            return make_req(REQ_RELEASE, 12'($urandom), 8'($urandom), 2'($urandom));
        if (pick < 85)
            return make_req(REQ_PULL, 12'($urandom), 8'($urandom), 2'($urandom));
        if (pick < 92)
            return make_req(REQ_PUSH, 12'($urandom), 8'($urandom), 2'($urandom));
        return make_req(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 12'($urandom),
                        8'($urandom), 2'($urandom));
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic issue(request_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {2'b00, r.slot, r.value, r.addr};
        do
            @(posedge clk);
        while (!s_tready);
        if (r.kind <= REQ_READ)
            sent_items++;
    endtask

    task automatic simple(logic [2:0] kind, logic [11:0] addr, logic [7:0] value,
                          logic [1:0] slot);
        issue(make_req(kind, addr, value, slot));
    endtask

    task automatic write_frame(int unsigned len, flaw_t flaw);
        int unsigned cut;
        logic [7:0]  value;
        cut = (len >= 6) ? $urandom_range(2, len - 4) : 2;
        for (int unsigned i = 0; i < len; i++)
        begin
            value = 8'($urandom);
            if (i == 0)
                value = MARK_FF;
            else if (i == 1)
                value = (flaw == FLAW_BAD_SOI) ? 8'($urandom_range(0, 8'hD7)) : MARK_SOI;
            else if (i == len - 2)
                value = MARK_FF;
            else if (i == len - 1)
                value = (flaw == FLAW_NO_EOI) ? 8'h00 : MARK_EOI;
            else if (flaw == FLAW_EXTRA_SOI && i == cut)
                value = MARK_FF;
            else if (flaw == FLAW_EXTRA_SOI && i == cut + 1)
                value = MARK_SOI;
            simple(REQ_WRITE, 12'(i), value, 2'($urandom));
        end
    endtask

    // Checked at falling edges so the monitor has seen the last transaction.
    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (board.pending_count() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned len;
        bit          hold_done;
        bit          pause_done;
        board      = new();
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        simple(REQ_PULL, 12'd0, 8'd0, 2'd0);
        simple(REQ_READ, 12'd4095, 8'd0, 2'd3);
        simple(REQ_UNUSED_LO, 12'd4095, 8'hFF, 2'd3);
        simple(REQ_UNUSED_HI, 12'd0, 8'd0, 2'd0);
        simple(REQ_RELEASE, 12'd0, 8'd0, 2'd0);
        simple(REQ_PUSH, 12'd0, 8'd0, 2'd0);
        simple(REQ_PULL, 12'd0, 8'd0, 2'd0);
        // longest image: end marker as late as the scan allows
        simple(REQ_WRITE, 12'd0, MARK_FF, 2'd0);
        simple(REQ_WRITE, 12'd1, MARK_SOI, 2'd0);
        simple(REQ_WRITE, 12'd4093, MARK_FF, 2'd0);
        simple(REQ_WRITE, 12'd4094, MARK_EOI, 2'd0);
        simple(REQ_WRITE, 12'd4095, 8'h5A, 2'd3);
        simple(REQ_WRITE, 12'd2, 8'd0, 2'd0);
        simple(REQ_PUSH, 12'd0, 8'd0, 2'd0);
        // released slot pushed again while still queued
        simple(REQ_RELEASE, 12'd0, 8'd0, 2'd0);
        simple(REQ_PUSH, 12'd0, 8'd0, 2'd0);
        simple(REQ_PULL, 12'd0, 8'd0, 2'd0);
        simple(REQ_RELEASE, 12'd0, 8'd0, 2'd0);
        simple(REQ_PULL, 12'd0, 8'd0, 2'd0);
        simple(REQ_READ, 12'd4095, 8'd0, 2'd0);
        // second start marker inside the image
        simple(REQ_WRITE, 12'd2, MARK_FF, 2'd0);
        simple(REQ_WRITE, 12'd3, MARK_SOI, 2'd0);
        simple(REQ_PUSH, 12'd0, 8'd0, 2'd0);
        simple(REQ_PULL, 12'd0, 8'd0, 2'd0);
        repeat (SLOTS + 1) simple(REQ_PUSH, 12'd0, 8'd0, 2'd0);

        while (sent_items < ITEM_TARGET)
        begin
            if (!hold_done && sent_items >= 200)
            begin
                hold_done     = 1'b1;
                hold_off_left = 600;
                repeat (32) simple(REQ_WRITE, 12'($urandom), 8'($urandom), 2'($urandom));
            end
            if (!pause_done && sent_items >= 380)
            begin
                pause_done = 1'b1;
                wait_for_responses();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 1) == 0)
                    simple(REQ_RELEASE, 12'd0, 8'd0, 2'($urandom));
                if (pick < 45)
                    write_frame($urandom_range(4, 40), FLAW_NONE);
                else
                    write_frame($urandom_range(6, 40), flaw_t'($urandom_range(1, 3)));
                simple(REQ_PUSH, 12'($urandom), 8'($urandom), 2'($urandom));
                if (pick >= 45 || $urandom_range(0, 9) < 6)
                    simple(REQ_PULL, 12'($urandom), 8'($urandom), 2'($urandom));
            end
            else
                repeat ($urandom_range(1, 6)) issue(random_request());
        end

        wait_for_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
